[design/ffr_pkg.sv]
// ffr_pkg: shared types and constants of the flood fill block
// used by ffr_ctrl, ffr_dp and flood_fill_region_8_connected_top; no dependencies
package ffr_pkg;

	localparam int MAX_COLS_DEF = 64;
	localparam int MAX_ROWS_DEF = 64;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_FILL  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [6:0] WIDTH_RST  = 7'd64;
	localparam logic [6:0] HEIGHT_RST = 7'd64;

	typedef struct packed {
		logic accept;
		logic clr_pix;
		logic clr_vis;
		logic seed;
		logic pop;
		logic pix_rd;
		logic append;
		logic nb_rd;
		logic nb_chk;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic start_bad;
		logic clr_last;
		logic q_avail;
		logic pix_set;
		logic nb_last;
	} stat_t;

endpackage

[design/ffr_ctrl.sv]
// ffr_ctrl: sequencer of the flood fill block
// depends on ffr_pkg; drives ffr_dp through cmd_t and reads its stat_t
module ffr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     opcode,
	input  ffr_pkg::stat_t stat,
	output logic           busy,
	output ffr_pkg::cmd_t  cmd
);
	import ffr_pkg::*;

	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_CLR  = 4'd2;
	localparam logic [3:0] S_SEED = 4'd3;
	localparam logic [3:0] S_POP  = 4'd4;
	localparam logic [3:0] S_PIX  = 4'd5;
	localparam logic [3:0] S_TST  = 4'd6;
	localparam logic [3:0] S_NRD  = 4'd7;
	localparam logic [3:0] S_NCK  = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_INIT: begin
				// clear pixel and visited maps after reset
				cmd.clr_pix = 1'b1;
				cmd.clr_vis = 1'b1;
				if (stat.clr_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (opcode == OP_FILL) begin
						state_nx = stat.start_bad ? S_DONE : S_CLR;
					end
				end
			end
			S_CLR: begin
				cmd.clr_vis = 1'b1;
				if (stat.clr_last) state_nx = S_SEED;
			end
			S_SEED: begin
				cmd.seed = 1'b1;
				state_nx = S_POP;
			end
			S_POP: begin
				if (stat.q_avail) begin
					cmd.pop  = 1'b1;
					state_nx = S_PIX;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_PIX: begin
				cmd.pix_rd = 1'b1;
				state_nx   = S_TST;
			end
			S_TST: begin
				if (stat.pix_set) begin
					cmd.append = 1'b1;
					state_nx   = S_NRD;
				end else begin
					state_nx = S_POP;
				end
			end
			S_NRD: begin
				cmd.nb_rd = 1'b1;
				state_nx  = S_NCK;
			end
			S_NCK: begin
				cmd.nb_chk = 1'b1;
				state_nx   = stat.nb_last ? S_POP : S_NRD;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_nx   = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

[design/ffr_dp.sv]
// ffr_dp: maps, queue, region list, counters and result registers
// depends on ffr_pkg; commanded by ffr_ctrl
module ffr_dp #(
	parameter int MAX_COLS = ffr_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = ffr_pkg::MAX_ROWS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ffr_pkg::cmd_t  cmd,
	input  logic [1:0]     opcode,
	input  logic [5:0]     col,
	input  logic [5:0]     row,
	input  logic           pixel_value,
	input  logic [11:0]    list_index,
	input  logic [6:0]     img_w,
	input  logic [6:0]     img_h,
	output ffr_pkg::stat_t stat,
	output logic           done,
	output logic [12:0]    region_count,
	output logic [5:0]     out_col,
	output logic [5:0]     out_row,
	output logic           entry_valid,
	output logic           start_error
);
	import ffr_pkg::*;

	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int AW    = CW + RW;
	localparam int DEPTH = 1 << AW;
	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int NW    = $clog2(CELLS + 1);
	localparam int WW    = (CW + 1 > 7) ? CW + 1 : 7;
	localparam int HW    = (RW + 1 > 7) ? RW + 1 : 7;
	localparam int LW    = NW + 12;

	logic          pix_mem [DEPTH];
	logic          vis_mem [DEPTH];
	logic [AW-1:0] q_mem   [DEPTH];
	logic [AW-1:0] l_mem   [DEPTH];

	logic [AW-1:0] clr_q;
	logic [NW-1:0] len_q, head_q, tail_q;
	logic          done_q, valid_q, err_q;
	logic [CW-1:0] st_c_q, ni_q, ihi_q;
	logic [RW-1:0] st_r_q, nj_q, jlo_q, jhi_q;
	logic [AW-1:0] q_rd_q, l_rd_q;
	logic          pix_rd_q, vis_rd_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [CW-1:0] col_a, cur_c, ilo;
	logic [RW-1:0] row_a, cur_r, jlo, jhi;
	logic [CW-1:0] ihi;
	logic [WW:0]   cp1;
	logic [HW:0]   rp1;
	logic [AW-1:0] st_addr, nb_addr;
	logic          wr_ok, start_bad, in_range, nb_mark;
	logic          is_write, is_fill, is_read;

	assign w_eff = (WW'(img_w) > WW'(MAX_COLS)) ? WW'(MAX_COLS) : WW'(img_w);
	assign h_eff = (HW'(img_h) > HW'(MAX_ROWS)) ? HW'(MAX_ROWS) : HW'(img_h);

	assign col_a     = CW'(col);
	assign row_a     = RW'(row);
	assign wr_ok     = (11'(col) < 11'(MAX_COLS)) && (11'(row) < 11'(MAX_ROWS));
	assign start_bad = (WW'(col) >= w_eff) || (HW'(row) >= h_eff);
	assign in_range  = LW'(list_index) < LW'(len_q);

	assign is_write = cmd.accept && (opcode == OP_WRITE);
	assign is_fill  = cmd.accept && (opcode == OP_FILL);
	assign is_read  = cmd.accept && (opcode == OP_READ);

	assign cur_c   = q_rd_q[CW-1:0];
	assign cur_r   = q_rd_q[AW-1:CW];
	assign st_addr = {st_r_q, st_c_q};
	assign nb_addr = {nj_q, ni_q};
	assign nb_mark = cmd.nb_chk && !vis_rd_q && (tail_q < NW'(CELLS));

	// neighborhood of the current pixel, clipped to the image in use
	assign cp1 = (WW + 1)'(cur_c) + 1'b1;
	assign rp1 = (HW + 1)'(cur_r) + 1'b1;
	assign ilo = (cur_c == '0) ? '0 : cur_c - 1'b1;
	assign jlo = (cur_r == '0) ? '0 : cur_r - 1'b1;
	assign ihi = (cp1 < (WW + 1)'(w_eff)) ? CW'(cp1) : CW'(w_eff - 1'b1);
	assign jhi = (rp1 < (HW + 1)'(h_eff)) ? RW'(rp1) : RW'(h_eff - 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.clr_pix) begin
			pix_mem[clr_q] <= 1'b0;
		end else if (is_write && wr_ok) begin
			pix_mem[{row_a, col_a}] <= pixel_value;
		end
		if (cmd.pix_rd) pix_rd_q <= pix_mem[q_rd_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_vis) begin
			vis_mem[clr_q] <= 1'b0;
		end else if (cmd.seed) begin
			vis_mem[st_addr] <= 1'b1;
		end else if (nb_mark) begin
			vis_mem[nb_addr] <= 1'b1;
		end
		if (cmd.nb_rd) vis_rd_q <= vis_mem[nb_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.seed) begin
			q_mem[AW'(tail_q)] <= st_addr;
		end else if (nb_mark) begin
			q_mem[AW'(tail_q)] <= nb_addr;
		end
		if (cmd.pop) q_rd_q <= q_mem[AW'(head_q)];
	end

	always_ff @(posedge clk) begin
		if (cmd.append) l_mem[AW'(len_q)] <= q_rd_q;
		if (is_read) l_rd_q <= l_mem[AW'(list_index)];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (is_fill) begin
			st_c_q <= col_a;
			st_r_q <= row_a;
		end
		if (cmd.append) begin
			ni_q  <= ilo;
			nj_q  <= jlo;
			ihi_q <= ihi;
			jlo_q <= jlo;
			jhi_q <= jhi;
		end else if (cmd.nb_chk) begin
			// column outer, row inner
			if (nj_q == jhi_q) begin
				nj_q <= jlo_q;
				ni_q <= ni_q + 1'b1;
			end else begin
				nj_q <= nj_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			len_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			done_q  <= 1'b0;
			valid_q <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			if (cmd.clr_pix || cmd.clr_vis) clr_q <= clr_q + 1'b1;
			if (is_fill) begin
				len_q  <= '0;
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (cmd.append) len_q <= len_q + 1'b1;
				if (cmd.pop) head_q <= head_q + 1'b1;
				if (cmd.seed || nb_mark) tail_q <= tail_q + 1'b1;
			end
			done_q  <= (cmd.accept && (opcode != OP_FILL)) || cmd.finish;
			valid_q <= is_read && in_range;
			if (cmd.accept) err_q <= is_fill && start_bad;
		end
	end

	assign stat.start_bad = start_bad;
	assign stat.clr_last  = &clr_q;
	assign stat.q_avail   = head_q < tail_q;
	assign stat.pix_set   = pix_rd_q;
	assign stat.nb_last   = (ni_q == ihi_q) && (nj_q == jhi_q);

	assign done         = done_q;
	assign region_count = 13'(len_q);
	assign out_col      = valid_q ? 6'(l_rd_q[CW-1:0]) : 6'd0;
	assign out_row      = valid_q ? 6'(l_rd_q[AW-1:CW]) : 6'd0;
	assign entry_valid  = valid_q;
	assign start_error  = err_q;

endmodule

[design/flood_fill_region_8_connected_top.sv]
// Flood fill block: 8-connected breadth-first fill over a stored binary image.
// A write (opcode 0), a list read (opcode 2) or a no-op is taken in any cycle in
// which busy is low and gives its result, marked by done, in the next cycle, so
// these run one per cycle. A fill (opcode 1) raises busy; it first clears the
// visited map, all 2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) entries (4096 by default),
// then seeds the queue, pops each queued pixel and reads it, and for each set
// pixel appends it to the region list and examines its neighbors; after the final
// empty-queue check it finishes, and done rises in the cycle in which busy drops.
// A start outside the image skips the walk and returns. After reset the pixel map
// is cleared in the same sweep with busy high. Results cannot be stalled: done is a one-cycle
// strobe. depends on ffr_pkg, ffr_ctrl, ffr_dp
module flood_fill_region_8_connected_top #(
	parameter int MAX_COLS = ffr_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = ffr_pkg::MAX_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [5:0]  col,
	input  logic [5:0]  row,
	input  logic        pixel_value,
	input  logic [11:0] list_index,
	output logic        done,
	output logic [12:0] region_count,
	output logic [5:0]  out_col,
	output logic [5:0]  out_row,
	output logic        entry_valid,
	output logic        start_error,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ffr_pkg::*;

	logic [6:0] img_w_q, img_h_q;
	logic       cfg_wr;
	cmd_t       cmd;
	stat_t      stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= WIDTH_RST;
			img_h_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_WIDTH) begin
				img_w_q <= pwdata[6:0];
			end else begin
				img_h_q <= pwdata[6:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_HEIGHT) ? {25'd0, img_h_q} : {25'd0, img_w_q};

	ffr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	ffr_dp #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.opcode       (opcode),
		.col          (col),
		.row          (row),
		.pixel_value  (pixel_value),
		.list_index   (list_index),
		.img_w        (img_w_q),
		.img_h        (img_h_q),
		.stat         (stat),
		.done         (done),
		.region_count (region_count),
		.out_col      (out_col),
		.out_row      (out_row),
		.entry_valid  (entry_valid),
		.start_error  (start_error)
	);

`ifndef ASSERT_OFF
	a_quick_op: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode != OP_FILL) |=> done)
		else $error("write or read transaction gave no result in the next cycle");

	a_fill_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_FILL) |=> busy)
		else $error("fill transaction did not hold busy");

	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && start_error) |-> (region_count == 13'd0))
		else $error("failed fill start left a nonempty region");

	a_valid_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		entry_valid |-> (done && !start_error))
		else $error("entry_valid outside a read result");
`endif

endmodule
